[sv/assert_macros.svh]
// Assertion helpers used by the arbiter back end.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define TSA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define TSA_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TSA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/tsa_pkg.sv]
// ----------------------------------------------------------------------------
// Tenant slice arbiter package
// Shared constants and the item type that links the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

package tsa_pkg;

    localparam int TENANTS_DEF = 16;
    localparam int PHASES = 52;
    localparam logic [31:0] EPOCH_RESET = 32'd1000;

    typedef logic signed [33:0] slice_t;
    typedef logic signed [39:0] cum_t;

    typedef struct packed {
        logic [3:0]  tenant;
        logic        req;
        logic        emit;
        slice_t      deadline;
        logic        last_of_epoch;
    } qitem_t;

    typedef enum logic {
        KIND_DURATION = 1'b0,
        KIND_GRANT    = 1'b1
    } kind_t;

endpackage

`default_nettype wire

[sv/tsa_front.sv]
// ----------------------------------------------------------------------------
// Tenant slice arbiter front end
// Classifies a slot beat and computes the request deadline and phase.
// ----------------------------------------------------------------------------
`default_nettype none

module tsa_front
    import tsa_pkg::*;
#(
    parameter int TENANTS = TENANTS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        accept,
    input  wire logic [31:0] epoch,
    input  wire logic [3:0]  tenant,
    input  wire logic        has_request,
    input  wire logic        resumed,
    input  wire logic [31:0] total_run_time,
    input  wire logic [31:0] run_so_far,
    input  wire logic        profile_found,
    input  wire logic [31:0] short_estimate,
    input  wire logic [31:0] long_estimate,
    input  wire logic        last_of_epoch,
    output qitem_t           item
);

    localparam int TW = (TENANTS > 1) ? $clog2(TENANTS) : 1;

    logic [5:0]    phase_reg [TENANTS];
    logic [TW-1:0] tidx;
    logic          in_range;
    logic          resumed_ok;
    logic [5:0]    phase;
    logic          step_phase;
    slice_t        d;

    assign tidx       = TW'(tenant);
    assign in_range   = (int'(tenant) < TENANTS);
    assign resumed_ok = resumed && (run_so_far != 32'd0);
    assign phase      = phase_reg[tidx];
    assign step_phase = accept && has_request && in_range && !resumed_ok && profile_found;

    always_comb
    begin
        if (resumed_ok)
        begin
            d = slice_t'({2'b00, total_run_time}) - slice_t'({2'b00, run_so_far});
        end
        else if (profile_found)
        begin
            d = (phase > 6'd1) ? slice_t'({2'b00, long_estimate})
                               : slice_t'({2'b00, short_estimate});
        end
        else
        begin
            d = slice_t'({2'b00, epoch});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TENANTS; i++)
            begin
                phase_reg[i] <= 6'd0;
            end
        end
        else if (step_phase)
        begin
            phase_reg[tidx] <= (int'(phase) + 1 >= PHASES) ? 6'd0 : phase + 6'd1;
        end
    end

    always_comb
    begin
        item.tenant        = tenant;
        item.req           = has_request && in_range;
        item.emit          = has_request && in_range && !resumed_ok;
        item.deadline      = d;
        item.last_of_epoch = last_of_epoch;
    end

endmodule

`default_nettype wire

[sv/tsa_queue.sv]
// ----------------------------------------------------------------------------
// Tenant slice arbiter item queue
// Two-entry queue between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module tsa_queue
    import tsa_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  qitem_t    push_item,
    input  wire logic pop,
    output qitem_t    pop_item,
    output logic      empty
);

    qitem_t     slot_reg [2];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] count_reg;

    assign empty    = (count_reg == 2'd0);
    assign pop_item = slot_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (pop)
            begin
                rptr_reg <= ~rptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

[sv/tsa_back.sv]
// ----------------------------------------------------------------------------
// Tenant slice arbiter back end
// Records requests, runs the epoch-end scans and the grant step, and
// presents the result beats.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module tsa_back
    import tsa_pkg::*;
#(
    parameter int TENANTS = TENANTS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [31:0] epoch,
    input  wire logic        q_empty,
    input  qitem_t           q_item,
    output logic             q_pop,
    output logic             active,
    output logic             strobe,
    output logic             kind,
    output logic [3:0]       target_tenant,
    output logic [31:0]      duration,
    output logic             last
);

    localparam int TW = (TENANTS > 1) ? $clog2(TENANTS) : 1;
    localparam logic [TW-1:0] LAST_IDX = TW'(TENANTS - 1);

    typedef enum logic [12:0] {
        ST_IDLE   = 13'b0000000000001,
        ST_SCAN   = 13'b0000000000010,
        ST_PLAN   = 13'b0000000000100,
        ST_REFILL = 13'b0000000001000,
        ST_RFEND  = 13'b0000000010000,
        ST_BOOST  = 13'b0000000100000,
        ST_ACCUM  = 13'b0000001000000,
        ST_SELECT = 13'b0000010000000,
        ST_GRANT  = 13'b0000100000000,
        ST_MUL    = 13'b0001000000000,
        ST_CMP    = 13'b0010000000000,
        ST_FINISH = 13'b0100000000000,
        ST_OUTDUR = 13'b1000000000000
    } state_t;

    state_t state_reg;
    logic   out_grant_reg;

    qitem_t        item_reg;
    logic [TW-1:0] idx_reg;
    logic [TENANTS-1:0] req_reg, pend_reg, serv_reg, blk_reg, newp_reg;
    slice_t dl_reg    [TENANTS];
    slice_t bs_reg    [TENANTS];
    slice_t allot_reg [TENANTS];
    cum_t   cum_reg   [TENANTS];

    logic          cv_reg;
    logic [TW-1:0] ct_reg;
    cum_t          ss_reg;
    logic [31:0]   silent_reg;
    logic          any_req_reg;
    slice_t        maxd_reg;
    logic [TW-1:0] first_req_reg;
    slice_t        omax_reg;
    logic          first_blk_reg;
    logic          grant_reg;
    logic [TW-1:0] gkey_reg;
    logic [63:0]   waited_reg;

    logic [TW-1:0] addr;
    slice_t        rd_dl, rd_bs, rd_allot;
    cum_t          rd_cum;
    logic [TW-1:0] lowest_pend;
    logic [TW-1:0] next_key;
    logic          next_found;
    logic [TW-1:0] tidx;
    logic [40:0]   cum_sum;
    cum_t          cum_sat;
    logic          cur_lost;

    assign addr     = (state_reg == ST_GRANT || state_reg == ST_CMP) ? ct_reg : idx_reg;
    assign rd_dl    = dl_reg[addr];
    assign rd_bs    = bs_reg[addr];
    assign rd_allot = allot_reg[addr];
    assign rd_cum   = cum_reg[addr];
    assign tidx     = TW'(q_item.tenant);

    assign cum_sum = 41'(rd_cum) + 41'(rd_dl);
    always_comb
    begin
        if (cum_sum[40] != cum_sum[39])
        begin
            cum_sat = cum_sum[40] ? {1'b1, 39'd0} : {1'b0, {39{1'b1}}};
        end
        else
        begin
            cum_sat = cum_sum[39:0];
        end
    end

    // Lowest pending tenant, and the successor or predecessor of the key.
    always_comb
    begin
        lowest_pend = '0;
        for (int i = TENANTS - 1; i >= 0; i--)
        begin
            if (pend_reg[i])
            begin
                lowest_pend = TW'(i);
            end
        end
    end

    always_comb
    begin
        next_found = 1'b0;
        next_key   = '0;
        for (int i = 0; i < TENANTS; i++)
        begin
            if (pend_reg[i] && (i < int'(ct_reg)))
            begin
                next_found = 1'b1;
                next_key   = TW'(i);
            end
        end
        for (int i = TENANTS - 1; i >= 0; i--)
        begin
            if (pend_reg[i] && (i > int'(ct_reg)))
            begin
                next_found = 1'b1;
                next_key   = TW'(i);
            end
        end
    end

    assign cur_lost = !cv_reg || (int'(ct_reg) >= TENANTS) || !pend_reg[ct_reg];

    assign q_pop  = (state_reg == ST_IDLE) && !q_empty;
    assign active = (state_reg != ST_IDLE) || out_grant_reg;

    assign strobe        = (state_reg == ST_OUTDUR) || out_grant_reg;
    assign kind          = out_grant_reg ? KIND_GRANT : KIND_DURATION;
    assign target_tenant = out_grant_reg ? 4'(gkey_reg) : item_reg.tenant;
    assign duration      = out_grant_reg ? 32'd0 : item_reg.deadline[31:0];
    assign last          = out_grant_reg || !grant_reg;

    // Payload stores.
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            item_reg <= q_item;
            if (q_item.req)
            begin
                dl_reg[tidx] <= q_item.deadline;
            end
        end
        if (state_reg == ST_REFILL && blk_reg[idx_reg])
        begin
            cum_reg[idx_reg]   <= cum_t'(rd_bs);
            allot_reg[idx_reg] <= rd_bs;
        end
        if (state_reg == ST_ACCUM && req_reg[idx_reg])
        begin
            if (!serv_reg[idx_reg])
            begin
                cum_reg[idx_reg]   <= pend_reg[idx_reg] ? cum_sat : cum_t'(rd_dl);
                allot_reg[idx_reg] <= rd_dl;
            end
            else if (!blk_reg[idx_reg])
            begin
                bs_reg[idx_reg] <= rd_dl;
            end
        end
        if (state_reg == ST_MUL)
        begin
            waited_reg <= 64'(epoch) * 64'(silent_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_grant_reg <= 1'b0;
            idx_reg       <= '0;
            req_reg       <= '0;
            pend_reg      <= '0;
            serv_reg      <= '0;
            blk_reg       <= '0;
            newp_reg      <= '0;
            cv_reg        <= 1'b0;
            ct_reg        <= '0;
            ss_reg        <= '0;
            silent_reg    <= '0;
            any_req_reg   <= 1'b0;
            maxd_reg      <= '0;
            first_req_reg <= '0;
            omax_reg      <= '0;
            first_blk_reg <= 1'b0;
            grant_reg     <= 1'b0;
            gkey_reg      <= '0;
        end
        else
        begin
            out_grant_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (!q_empty && !out_grant_reg)
                    begin
                        grant_reg <= 1'b0;
                        if (q_item.req)
                        begin
                            req_reg[tidx] <= 1'b1;
                        end
                        if (q_item.last_of_epoch)
                        begin
                            idx_reg     <= '0;
                            any_req_reg <= 1'b0;
                            maxd_reg    <= '0;
                            state_reg   <= ST_SCAN;
                        end
                        else if (q_item.emit)
                        begin
                            state_reg <= ST_OUTDUR;
                        end
                    end
                end
                ST_SCAN:
                begin
                    if (req_reg[idx_reg])
                    begin
                        if (!any_req_reg || rd_dl > maxd_reg)
                        begin
                            maxd_reg <= rd_dl;
                        end
                        if (!any_req_reg)
                        begin
                            first_req_reg <= idx_reg;
                        end
                        any_req_reg <= 1'b1;
                    end
                    idx_reg <= idx_reg + 1'b1;
                    if (idx_reg == LAST_IDX)
                    begin
                        state_reg <= ST_PLAN;
                    end
                end
                ST_PLAN:
                begin
                    state_reg <= ST_BOOST;
                    if (pend_reg == '0)
                    begin
                        if (any_req_reg)
                        begin
                            cv_reg <= 1'b1;
                            ct_reg <= first_req_reg;
                        end
                        ss_reg   <= '0;
                        serv_reg <= '0;
                        if (blk_reg != '0)
                        begin
                            idx_reg       <= '0;
                            omax_reg      <= '0;
                            first_blk_reg <= 1'b0;
                            state_reg     <= ST_REFILL;
                        end
                    end
                end
                ST_REFILL:
                begin
                    if (blk_reg[idx_reg])
                    begin
                        if (rd_bs > omax_reg)
                        begin
                            omax_reg <= rd_bs;
                        end
                        if (!first_blk_reg)
                        begin
                            if (!cv_reg || idx_reg < ct_reg)
                            begin
                                cv_reg <= 1'b1;
                                ct_reg <= idx_reg;
                            end
                            first_blk_reg <= 1'b1;
                        end
                        pend_reg[idx_reg] <= 1'b1;
                        newp_reg[idx_reg] <= 1'b1;
                        blk_reg[idx_reg]  <= 1'b0;
                    end
                    idx_reg <= idx_reg + 1'b1;
                    if (idx_reg == LAST_IDX)
                    begin
                        state_reg <= ST_RFEND;
                    end
                end
                ST_RFEND:
                begin
                    if (omax_reg > 0)
                    begin
                        ss_reg <= cum_t'(omax_reg);
                    end
                    state_reg <= ST_BOOST;
                end
                ST_BOOST:
                begin
                    if (any_req_reg && (serv_reg == '0) && (ss_reg < cum_t'(maxd_reg)))
                    begin
                        ss_reg <= cum_t'(maxd_reg);
                    end
                    idx_reg   <= '0;
                    state_reg <= ST_ACCUM;
                end
                ST_ACCUM:
                begin
                    if (req_reg[idx_reg])
                    begin
                        if (!serv_reg[idx_reg])
                        begin
                            if (!pend_reg[idx_reg])
                            begin
                                pend_reg[idx_reg] <= 1'b1;
                                newp_reg[idx_reg] <= 1'b1;
                            end
                        end
                        else if (!blk_reg[idx_reg])
                        begin
                            blk_reg[idx_reg] <= 1'b1;
                        end
                    end
                    idx_reg <= idx_reg + 1'b1;
                    if (idx_reg == LAST_IDX)
                    begin
                        state_reg <= ST_SELECT;
                    end
                end
                ST_SELECT:
                begin
                    if (pend_reg != '0)
                    begin
                        if (cur_lost)
                        begin
                            cv_reg <= 1'b1;
                            ct_reg <= lowest_pend;
                        end
                        state_reg <= ST_GRANT;
                    end
                    else
                    begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_GRANT:
                begin
                    gkey_reg  <= ct_reg;
                    state_reg <= ST_FINISH;
                    if (req_reg[ct_reg] || newp_reg[ct_reg])
                    begin
                        newp_reg[ct_reg] <= 1'b0;
                        grant_reg        <= 1'b1;
                        silent_reg       <= '0;
                        if (rd_cum >= ss_reg || rd_cum < 0)
                        begin
                            cv_reg           <= next_found;
                            ct_reg           <= next_found ? next_key : ct_reg;
                            pend_reg[ct_reg] <= 1'b0;
                            serv_reg[ct_reg] <= 1'b1;
                        end
                    end
                    else
                    begin
                        if (silent_reg != '1)
                        begin
                            silent_reg <= silent_reg + 32'd1;
                        end
                        if ($countones(pend_reg) > 1)
                        begin
                            state_reg <= ST_MUL;
                        end
                    end
                end
                ST_MUL:
                begin
                    state_reg <= ST_CMP;
                end
                ST_CMP:
                begin
                    if (rd_allot < 0 || waited_reg >= {31'd0, rd_allot[32:0]})
                    begin
                        cv_reg           <= next_found;
                        ct_reg           <= next_found ? next_key : ct_reg;
                        pend_reg[ct_reg] <= 1'b0;
                        serv_reg[ct_reg] <= 1'b1;
                    end
                    state_reg <= ST_FINISH;
                end
                ST_FINISH:
                begin
                    req_reg <= '0;
                    if (item_reg.emit)
                    begin
                        state_reg <= ST_OUTDUR;
                    end
                    else
                    begin
                        out_grant_reg <= grant_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                ST_OUTDUR:
                begin
                    out_grant_reg <= grant_reg;
                    state_reg     <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    `TSA_ASSERT_IMPL(a_grant_beat, strobe && kind, last && (duration == 32'd0), "grant beat malformed")
    `TSA_ASSERT_NEXT(a_dur_then_grant, strobe && !kind && !last, strobe && kind, "grant lost")
    `TSA_ASSERT_NEXT(a_grant_once, strobe && kind, !strobe, "result repeated")
    `TSA_ASSERT_IMPL(a_no_pop_busy, q_pop, !out_grant_reg && (state_reg == ST_IDLE), "bad pop")

endmodule

`default_nettype wire

[sv/tenant_slice_arbiter_unit.sv]
// ----------------------------------------------------------------------------
// Tenant slice arbiter unit
// Epoch-based multi-tenant kernel arbiter with a front classifier, a small
// item queue and a back end that runs the epoch-end arbitration.
// ----------------------------------------------------------------------------
// One slot beat is taken while busy is low. A slot that is not the last of
// its epoch gives at most one duration beat. The last slot of an epoch runs
// two or three scans over the tenant tables (the refill scan only when no
// tenant is pending and some are blocked), one tenant per cycle, plus a few
// control steps and a registered 32x32 multiply for the silence timeout,
// then up to two result beats (duration, then grant). Results appear for one
// cycle on strobe and must be taken then; the receiver cannot stall. No
// clearing pass follows reset.
`default_nettype none

module tenant_slice_arbiter_unit
    import tsa_pkg::*;
#(
    parameter int TENANTS = TENANTS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [3:0]  tenant,
    input  wire logic        has_request,
    input  wire logic        resumed,
    input  wire logic [31:0] total_run_time,
    input  wire logic [31:0] run_so_far,
    input  wire logic        profile_found,
    input  wire logic [31:0] short_estimate,
    input  wire logic [31:0] long_estimate,
    input  wire logic        last_of_epoch,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] cfg_data,
    output logic             strobe,
    output logic             kind,
    output logic [3:0]       target_tenant,
    output logic [31:0]      duration,
    output logic             last
);

    logic [31:0] epoch_reg;
    logic        accept;
    logic        q_empty;
    logic        q_pop;
    logic        back_active;
    qitem_t      f_item;
    qitem_t      q_item;

    assign cfg_ready = 1'b1;
    assign busy      = !q_empty || back_active;
    assign accept    = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            epoch_reg <= EPOCH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            epoch_reg <= cfg_data;
        end
    end

    tsa_front #(.TENANTS(TENANTS)) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .epoch          (epoch_reg),
        .tenant         (tenant),
        .has_request    (has_request),
        .resumed        (resumed),
        .total_run_time (total_run_time),
        .run_so_far     (run_so_far),
        .profile_found  (profile_found),
        .short_estimate (short_estimate),
        .long_estimate  (long_estimate),
        .last_of_epoch  (last_of_epoch),
        .item           (f_item)
    );

    tsa_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_item (f_item),
        .pop       (q_pop),
        .pop_item  (q_item),
        .empty     (q_empty)
    );

    tsa_back #(.TENANTS(TENANTS)) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .epoch         (epoch_reg),
        .q_empty       (q_empty),
        .q_item        (q_item),
        .q_pop         (q_pop),
        .active        (back_active),
        .strobe        (strobe),
        .kind          (kind),
        .target_tenant (target_tenant),
        .duration      (duration),
        .last          (last)
    );

endmodule

`default_nettype wire

[dv/tenant_slice_arbiter_unit_test.sv]
// ----------------------------------------------------------------------------
// Tenant slice arbiter unit testbench
// Drives slot beats epoch by epoch, predicts duration and grant beats with a
// cycle-free model of the arbiter, and checks every result beat in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tenant_slice_arbiter_unit_test
    import tsa_pkg::*;
();

    localparam int NT = TENANTS_DEF;
    localparam longint CUM_HI = 64'sd549755813887;
    localparam longint CUM_LO = -CUM_HI - 1;
    localparam int SETTLE_CYCLES = 3 * NT + 40;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_ITEMS = 650;

    typedef struct {
        logic [3:0]  tenant;
        logic        has_request;
        logic        resumed;
        logic [31:0] total_run_time;
        logic [31:0] run_so_far;
        logic        profile_found;
        logic [31:0] short_estimate;
        logic [31:0] long_estimate;
        logic        last_of_epoch;
    } slot_t;

    typedef struct {
        kind_t       kind;
        logic [3:0]  tgt;
        logic [31:0] dur;
        logic        lst;
    } beat_t;

    // Directed row: a slot plus an optional typed duration beat.
    typedef struct {
        slot_t       s;
        bit          typed;
        logic [31:0] typed_dur;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [3:0]  tenant = '0;
    logic        has_request = 1'b0;
    logic        resumed = 1'b0;
    logic [31:0] total_run_time = '0;
    logic [31:0] run_so_far = '0;
    logic        profile_found = 1'b0;
    logic [31:0] short_estimate = '0;
    logic [31:0] long_estimate = '0;
    logic        last_of_epoch = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data = '0;
    logic        strobe;
    logic        kind;
    logic [3:0]  target_tenant;
    logic [31:0] duration;
    logic        last;

    tenant_slice_arbiter_unit dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .tenant(tenant), .has_request(has_request), .resumed(resumed),
        .total_run_time(total_run_time), .run_so_far(run_so_far),
        .profile_found(profile_found), .short_estimate(short_estimate),
        .long_estimate(long_estimate), .last_of_epoch(last_of_epoch),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .strobe(strobe), .kind(kind), .target_tenant(target_tenant),
        .duration(duration), .last(last)
    );

    always #4 clk = ~clk;

    // Arbiter state as the testbench sees it.
    logic [31:0] sched_epoch;
    logic [5:0]  phase_of [NT];
    bit          requested [NT];
    slice_t      deadline_of [NT];
    bit          pend [NT];
    bit          served [NT];
    bit          blk [NT];
    slice_t      blk_slice [NT];
    cum_t        cum_slice [NT];
    slice_t      allot [NT];
    bit          fresh [NT];
    bit          cur_valid;
    int          cur_tenant;
    cum_t        svc_slice;
    logic [31:0] silent;

    beat_t       expected_beats[$];
    beat_t       pending_beats[$];
    int          mismatches = 0;
    int          idle_pct = 0;
    int          quiet_cycles = 0;
    int          items_sent = 0;

    function automatic void add_beat(kind_t k, int t, logic [31:0] d);
        beat_t b;
        b.kind = k;
        b.tgt  = 4'(t);
        b.dur  = d;
        b.lst  = 1'b0;
        pending_beats.insert(pending_beats.size(), b);
    endfunction

    function automatic void advance_from(int key);
        int nxt;
        nxt = -1;
        for (int i = key + 1; i < NT; i++)
            if (nxt < 0 && pend[i]) nxt = i;
        for (int i = key - 1; i >= 0; i--)
            if (nxt < 0 && pend[i]) nxt = i;
        if (nxt < 0)
            cur_valid = 1'b0;
        else
        begin
            cur_valid = 1'b1;
            cur_tenant = nxt;
        end
        pend[key] = 1'b0;
        served[key] = 1'b1;
    endfunction

    function automatic void close_epoch();
        bit any_req, any_pend, any_serv, any_blk, got_first;
        slice_t maxd, omax;
        longint sum;
        int npend, key;
        longint unsigned waited;
        any_req = 0; any_pend = 0; any_serv = 0; any_blk = 0;
        maxd = 0;
        for (int i = 0; i < NT; i++)
        begin
            if (requested[i])
            begin
                if (!any_req || deadline_of[i] > maxd) maxd = deadline_of[i];
                any_req = 1;
            end
            if (pend[i]) any_pend = 1;
            if (blk[i]) any_blk = 1;
        end
        if (!any_pend)
        begin
            got_first = 0;
            for (int i = 0; i < NT; i++)
                if (requested[i] && !got_first)
                begin
                    cur_valid = 1; cur_tenant = i; got_first = 1;
                end
            svc_slice = 0;
            for (int i = 0; i < NT; i++) served[i] = 0;
            if (any_blk)
            begin
                omax = 0;
                got_first = 0;
                for (int i = 0; i < NT; i++)
                begin
                    if (blk[i])
                    begin
                        if (blk_slice[i] > omax) omax = blk_slice[i];
                        if (!got_first)
                        begin
                            if (!cur_valid || i < cur_tenant)
                            begin
                                cur_valid = 1; cur_tenant = i;
                            end
                            got_first = 1;
                        end
                        pend[i] = 1;
                        fresh[i] = 1;
                        cum_slice[i] = blk_slice[i];
                        allot[i] = blk_slice[i];
                        blk[i] = 0;
                    end
                end
                if (omax > 0) svc_slice = omax;
            end
        end
        for (int i = 0; i < NT; i++) if (served[i]) any_serv = 1;
        if (any_req && !any_serv && svc_slice < maxd) svc_slice = maxd;
        for (int i = 0; i < NT; i++)
        begin
            if (!requested[i]) continue;
            if (!served[i])
            begin
                if (!pend[i])
                begin
                    pend[i] = 1; fresh[i] = 1;
                    cum_slice[i] = deadline_of[i];
                end
                else
                begin
                    sum = longint'(cum_slice[i]) + longint'(deadline_of[i]);
                    if (sum > CUM_HI) sum = CUM_HI;
                    if (sum < CUM_LO) sum = CUM_LO;
                    cum_slice[i] = cum_t'(sum);
                end
                allot[i] = deadline_of[i];
            end
            else if (!blk[i])
            begin
                blk[i] = 1;
                blk_slice[i] = deadline_of[i];
            end
        end
        npend = 0;
        for (int i = 0; i < NT; i++) if (pend[i]) npend++;
        if (npend != 0)
        begin
            if (!cur_valid || !pend[cur_tenant])
            begin
                got_first = 0;
                for (int i = 0; i < NT; i++)
                    if (pend[i] && !got_first)
                    begin
                        cur_valid = 1; cur_tenant = i; got_first = 1;
                    end
            end
            key = cur_tenant;
            if (requested[key] || fresh[key])
            begin
                fresh[key] = 0;
                add_beat(KIND_GRANT, key, '0);
                if (cum_slice[key] >= svc_slice || cum_slice[key] < 0) advance_from(key);
                silent = '0;
            end
            else
            begin
                if (silent != 32'hFFFF_FFFF) silent++;
                if (npend > 1)
                begin
                    waited = longint'(sched_epoch) * longint'(silent);
                    if (allot[key] < 0 || waited >= longint'(allot[key]))
                        advance_from(key);
                end
            end
        end
        for (int i = 0; i < NT; i++) requested[i] = 0;
    endfunction

    // Works out the beats that one accepted slot causes, into pending_beats.
    function automatic void predict_slot(slot_t s);
        slice_t d;
        int t;
        t = s.tenant;
        pending_beats.delete();
        if (s.has_request)
        begin
            if (s.resumed && s.run_so_far != 0)
                d = slice_t'({2'b00, s.total_run_time}) - slice_t'({2'b00, s.run_so_far});
            else
            begin
                if (s.profile_found)
                begin
                    d = slice_t'({2'b00, (phase_of[t] > 1) ? s.long_estimate
                                                           : s.short_estimate});
                    phase_of[t] = (phase_of[t] + 1 >= PHASES) ? 6'd0 : phase_of[t] + 6'd1;
                end
                else
                    d = slice_t'({2'b00, sched_epoch});
                add_beat(KIND_DURATION, t, d[31:0]);
            end
            deadline_of[t] = d;
            requested[t] = 1;
        end
        if (s.last_of_epoch) close_epoch();
        if (pending_beats.size() > 0) pending_beats[pending_beats.size() - 1].lst = 1'b1;
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(0, 3000);
            3: return 32'h8000_0000 + $urandom_range(0, 7);
            default: return $urandom;
        endcase
    endfunction

    function automatic slot_t random_slot(int t, bit lastflag);
        slot_t s;
        s.tenant = 4'(t);
        s.has_request = ($urandom_range(0, 9) != 0);
        s.resumed = ($urandom_range(0, 3) == 0);
        s.total_run_time = pick_value();
        s.run_so_far = ($urandom_range(0, 4) == 0) ? 32'h0 : pick_value();
        s.profile_found = 1'($urandom_range(0, 1));
        s.short_estimate = pick_value();
        s.long_estimate = pick_value();
        s.last_of_epoch = lastflag;
        return s;
    endfunction

    task automatic send_slot(slot_t s, bit typed, logic [31:0] typed_dur);
        beat_t b;
        while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        start <= 1'b1;
        tenant <= s.tenant;
        has_request <= s.has_request;
        resumed <= s.resumed;
        total_run_time <= s.total_run_time;
        run_so_far <= s.run_so_far;
        profile_found <= s.profile_found;
        short_estimate <= s.short_estimate;
        long_estimate <= s.long_estimate;
        last_of_epoch <= s.last_of_epoch;
        @(posedge clk);
        while (busy) @(posedge clk);
        predict_slot(s);
        if (typed)
        begin
            b.kind = KIND_DURATION;
            b.tgt = s.tenant;
            b.dur = typed_dur;
            b.lst = 1'b1;
            expected_beats.insert(expected_beats.size(), b);
        end
        else
            foreach (pending_beats[i])
                expected_beats.insert(expected_beats.size(), pending_beats[i]);
        items_sent++;
    endtask

    task automatic drain_and_settle();
        start <= 1'b0;
        @(posedge clk);
        while (expected_beats.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_epoch(logic [31:0] v);
        drain_and_settle();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        sched_epoch = v;
    endtask

    // One epoch: mostly ascending tenants ending on a marked slot; some noise.
    task automatic random_epoch();
        int density, lastt;
        slot_t s;
        if ($urandom_range(0, 99) < 85)
        begin
            density = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(5, 60);
            lastt = -1;
            for (int t = 0; t < NT; t++)
                if ($urandom_range(0, 99) < density) lastt = t;
            if (lastt < 0)
            begin
                s = random_slot($urandom_range(0, NT - 1), 1'b1);
                s.has_request = $urandom_range(0, 3) == 0;
                send_slot(s, 0, '0);
            end
            else
                for (int t = 0; t <= lastt; t++)
                    if (t == lastt || $urandom_range(0, 99) < density)
                        send_slot(random_slot(t, t == lastt), 0, '0);
        end
        else
            repeat ($urandom_range(1, 6))
                send_slot(random_slot($urandom_range(0, NT - 1), 1'($urandom_range(0, 1))),
                          0, '0);
    endtask

    function automatic row_t mk(int t, bit req, bit res, logic [31:0] trt, logic [31:0] hrf,
                                bit prof, logic [31:0] mn, logic [31:0] mx, bit lo,
                                bit typed, logic [31:0] td);
        row_t r;
        r.s = '{4'(t), req, res, trt, hrf, prof, mn, mx, lo};
        r.typed = typed;
        r.typed_dur = td;
        return r;
    endfunction

    row_t directed_rows[$];

    function automatic void put_row(row_t r);
        directed_rows.insert(directed_rows.size(), r);
    endfunction

    initial
    begin
        sched_epoch = EPOCH_RESET;
        for (int i = 0; i < NT; i++)
        begin
            phase_of[i] = 0; requested[i] = 0; deadline_of[i] = 0; pend[i] = 0;
            served[i] = 0; blk[i] = 0; blk_slice[i] = 0; cum_slice[i] = 0;
            allot[i] = 0; fresh[i] = 0;
        end
        cur_valid = 0; cur_tenant = 0; svc_slice = 0; silent = 0;

        // After reset: plain, profiled min at both extremes, resumed cases.
        put_row(mk(0, 1, 0, 0, 0, 0, 0, 0, 0, 1, 32'd1000));
        put_row(mk(1, 1, 0, 0, 0, 1, 0, 32'hFFFF_FFFF, 0, 1, 32'd0));
        put_row(mk(2, 1, 0, 0, 0, 1, 32'hFFFF_FFFF, 0, 0, 1, 32'hFFFF_FFFF));
        put_row(mk(3, 1, 1, 0, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0));
        put_row(mk(4, 1, 1, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 1, 32'd1000));
        put_row(mk(5, 0, 1, 5, 5, 1, 5, 5, 0, 0, 0));
        put_row(mk(15, 1, 1, 32'hFFFF_FFFF, 1, 1, 0, 0, 1, 0, 0));
        // Repeated tenant, profiled phase stepping to the long estimate.
        put_row(mk(1, 1, 0, 0, 0, 1, 7, 9, 0, 0, 0));
        put_row(mk(1, 1, 0, 0, 0, 1, 7, 9, 0, 0, 0));
        put_row(mk(2, 1, 0, 0, 0, 1, 0, 32'hFFFF_FFFF, 1, 0, 0));
        // Serviced tenants asking again get blocked; silent epochs follow.
        put_row(mk(0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        put_row(mk(15, 1, 0, 0, 0, 0, 0, 0, 1, 0, 0));
        put_row(mk(0, 1, 0, 0, 0, 0, 0, 0, 1, 0, 0));
        put_row(mk(7, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0));
        put_row(mk(7, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0));
        put_row(mk(7, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0));
        put_row(mk(3, 1, 1, 32'h7FFF_FFFF, 32'h10, 0, 0, 0, 1, 0, 0));
        put_row(mk(9, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0));
        put_row(mk(9, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0));
        put_row(mk(9, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_slot(directed_rows[i].s, directed_rows[i].typed, directed_rows[i].typed_dur);

        for (int ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0: write_epoch(32'd1);
                1: write_epoch(32'hFFFF_FFFF);
                default: write_epoch($urandom_range(1, 5000));
            endcase
            idle_pct = (ph == 0) ? 35 : (ph == 1) ? 52 : 0;
            items_sent = 0;
            while (items_sent < PHASE_ITEMS) random_epoch();
        end
        write_epoch(EPOCH_RESET);

        if (mismatches == 0 && expected_beats.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Result beats are taken on the edge that ends their cycle.
    always @(posedge clk)
    begin
        beat_t e;
        if (rst_n && strobe)
        begin
            if (expected_beats.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: kind %0d tenant %0d duration %h last %0d",
                             kind, target_tenant, duration, last);
            end
            else
            begin
                e = expected_beats.pop_front();
                if (kind !== e.kind || target_tenant !== e.tgt || duration !== e.dur
                    || last !== e.lst)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("beat mismatch: expected %0d/%0d/%h/%0d got %0d/%0d/%h/%0d",
                                 e.kind, e.tgt, e.dur, e.lst,
                                 kind, target_tenant, duration, last);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || strobe || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

endmodule

`default_nettype wire

[tenant_slice_arbiter_unit.f]
+incdir+sv
sv/tsa_pkg.sv
sv/tsa_front.sv
sv/tsa_queue.sv
sv/tsa_back.sv
sv/tenant_slice_arbiter_unit.sv
dv/tenant_slice_arbiter_unit_test.sv
